[hw/rtl/lcdns_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_pkg: shared types and constants
// Request, strobe and queue entry formats and the command codes used by the
// 4-bit character LCD command sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  // Request codes
  localparam logic [1:0] FUNC_INIT  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_GOTO  = 2'd2;
  localparam logic [1:0] FUNC_GLYPH = 2'd3;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_FUNCTION_SET    = 2'd0;
  localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd1;
  localparam logic [1:0] REG_CLEAR           = 2'd2;
  localparam logic [1:0] REG_ENTRY_MODE      = 2'd3;

  localparam logic [7:0] RST_FUNCTION_SET    = 8'h28;
  localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h0C;
  localparam logic [7:0] RST_CLEAR           = 8'h01;
  localparam logic [7:0] RST_ENTRY_MODE      = 8'h06;

  // Command byte pieces
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] CMD_SET_CGRAM  = 8'h40;
  localparam logic [7:0] ROW_TWO_BASE   = 8'h40;
  localparam logic [7:0] CGRAM_SLOT_MSK = 8'h38;
  localparam logic [1:0] ROW_FIRST      = 2'd1;

  // Init timing and wake-up nibbles
  localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
  localparam logic [3:0] FOURBIT_NIBBLE  = 4'h2;
  localparam logic [3:0] POWERUP_WAIT_MS = 4'd15;
  localparam logic [2:0] INIT_WAIT_MS    = 3'd5;
  localparam logic [2:0] TAIL_WAIT_MS    = 3'd6;

  // Last step index per request kind (strobe count minus one), and the wake-up strobe count
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 5'd11;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 5'd1;
  localparam logic [STEP_W-1:0] GLYPH_LAST_STEP = 5'd17;
  localparam logic [STEP_W-1:0] WAKE_STEPS      = 5'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  func;
    logic        register_select;
    logic [7:0]  data_byte;
    logic [7:0]  column;
    logic [1:0]  row;
    logic [2:0]  char_slot;
    logic [63:0] glyph_rows;
  } in_item_t;

  typedef struct packed {
    logic       reg_select_out;
    logic [3:0] nibble;
    logic [3:0] wait_before_ms;
    logic [2:0] wait_after_ms;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_BYTE,
    KIND_GLYPH
  } kind_t;

  // One classified request waiting for the strobe sequencer
  typedef struct packed {
    kind_t       kind;
    logic        rs;
    logic [7:0]  first_byte;
    logic [63:0] rows;
  } cmd_desc_t;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] display_control;
    logic [7:0] clear;
    logic [7:0] entry_mode;
  } cfg_words_t;

endpackage

`default_nettype wire

[hw/rtl/lcdns_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_front: request classifier
// Turns an accepted request into a queue entry: request kind, register
// select level and the first command or data byte.
// ----------------------------------------------------------------------------
module lcdns_front (
  input  lcdns_pkg::in_item_t  req,
  output lcdns_pkg::cmd_desc_t desc
);
  import lcdns_pkg::*;

  logic [7:0] row_base;
  logic [7:0] ddram_addr;

  assign row_base   = (req.row != ROW_FIRST) ? ROW_TWO_BASE : 8'h00;
  // wraps modulo 256, column zero lands on the previous line end
  assign ddram_addr = row_base + req.column - 8'd1;

  always_comb begin
    desc.rows = req.glyph_rows;
    unique case (req.func)
      FUNC_INIT: begin
        desc.kind       = KIND_INIT;
        desc.rs         = 1'b0;
        desc.first_byte = 8'h00;
      end
      FUNC_WRITE: begin
        desc.kind       = KIND_BYTE;
        desc.rs         = req.register_select;
        desc.first_byte = req.data_byte;
      end
      FUNC_GOTO: begin
        desc.kind       = KIND_BYTE;
        desc.rs         = 1'b0;
        desc.first_byte = CMD_SET_DDRAM | ddram_addr;
      end
      default: begin
        desc.kind       = KIND_GLYPH;
        desc.rs         = 1'b0;
        desc.first_byte = CMD_SET_CGRAM | ({2'b00, req.char_slot, 3'b000} & CGRAM_SLOT_MSK);
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/lcdns_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_queue: request queue
// Short first-in first-out buffer of classified requests between the
// classifier and the strobe sequencer.
// ----------------------------------------------------------------------------
module lcdns_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lcdns_pkg::cmd_desc_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output lcdns_pkg::cmd_desc_t head_data
);
  import lcdns_pkg::*;

  cmd_desc_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        entry_r[wr_ptr_r] <= push_data;
        wr_ptr_r          <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lcdns_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_back: strobe sequencer
// Steps through the strobes of the request at the queue head, one strobe per
// transfer slot, into a registered output stage.
// ----------------------------------------------------------------------------
module lcdns_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcdns_pkg::cfg_words_t cfg,
  input  logic                  head_valid,
  input  lcdns_pkg::cmd_desc_t  head_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcdns_pkg::out_item_t  out_data
);
  import lcdns_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         strobe;
  logic              advance;
  logic [STEP_W-1:0] init_idx;
  logic [7:0]        init_word;
  logic [3:0]        byte_idx;
  logic [2:0]        row_sel;
  logic [7:0]        glyph_byte;
  logic [7:0]        cur_byte;

  assign advance   = head_valid && (!out_valid_r || !out_stall);
  assign pop       = advance && strobe.last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // command bytes of init follow the four wake-up nibbles
  assign init_idx = step_r - WAKE_STEPS;
  always_comb begin
    case (init_idx[2:1])
      REG_FUNCTION_SET:    init_word = cfg.function_set;
      REG_DISPLAY_CONTROL: init_word = cfg.display_control;
      REG_CLEAR:           init_word = cfg.clear;
      default:             init_word = cfg.entry_mode;
    endcase
  end

  // glyph load: byte 0 is the CGRAM address, bytes 1..8 are pattern rows
  assign byte_idx   = step_r[STEP_W-1:1];
  assign row_sel    = byte_idx[2:0] - 3'd1;
  assign glyph_byte = head_data.rows[{row_sel, 3'b000} +: 8];

  always_comb begin
    strobe                = '0;
    cur_byte              = head_data.first_byte;
    unique case (head_data.kind)
      KIND_INIT: begin
        strobe.last = (step_r == INIT_LAST_STEP);
        if (step_r < WAKE_STEPS) begin
          strobe.nibble         = (step_r == WAKE_STEPS - 1'b1) ? FOURBIT_NIBBLE : WAKE_NIBBLE;
          strobe.wait_before_ms = (step_r == '0) ? POWERUP_WAIT_MS : 4'd0;
          strobe.wait_after_ms  = INIT_WAIT_MS;
        end else begin
          cur_byte      = init_word;
          strobe.nibble = init_idx[0] ? init_word[3:0] : init_word[7:4];
          if (init_idx[0]) begin
            strobe.wait_after_ms = strobe.last ? TAIL_WAIT_MS : INIT_WAIT_MS;
          end
        end
      end
      KIND_BYTE: begin
        strobe.last           = (step_r == BYTE_LAST_STEP);
        strobe.reg_select_out = head_data.rs;
        strobe.nibble         = step_r[0] ? cur_byte[3:0] : cur_byte[7:4];
      end
      KIND_GLYPH: begin
        strobe.last = (step_r == GLYPH_LAST_STEP);
        if (byte_idx != 4'd0) begin
          cur_byte              = glyph_byte;
          strobe.reg_select_out = 1'b1;
        end
        strobe.nibble = step_r[0] ? cur_byte[3:0] : cur_byte[7:4];
      end
      default: begin
        strobe.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        out_data_r  <= strobe;
        step_r      <= strobe.last ? '0 : step_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lcd_nibble_command_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_nibble_command_sequencer: 4-bit character LCD command sequencer
// Expands init, byte write, cursor goto and glyph load requests into
// enable strobes with register select, nibble and millisecond waits.
// ----------------------------------------------------------------------------
// Each accepted request becomes a run of strobe transfers on the out_ channel:
// init gives 12 (wake-up nibbles 3, 3, 3, 2, then the four configured command
// bytes), byte write and cursor goto give 2, glyph load gives 18. The strobe
// sequencer emits at most one strobe per cycle, fewer while the receiver
// stalls on the out_ channel. A two-entry request queue sits between the
// classifier and the sequencer, and the request being played out keeps its
// entry until its final strobe enters the output stage, so in_stall rises
// as soon as one request is waiting behind the one being played out. Waits
// are reported, not timed: the receiver inserts them. The four init command
// bytes sit in APB registers at byte addresses 0, 4, 8 and 12; change them
// only while no request is in flight.
// ----------------------------------------------------------------------------
module lcd_nibble_command_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcdns_pkg::in_item_t  in_data,
  // strobe channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdns_pkg::out_item_t out_data,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lcdns_pkg::*;

  cfg_words_t cfg_r;
  cmd_desc_t  front_desc;
  cmd_desc_t  head_desc;
  logic       q_full;
  logic       head_valid;
  logic       head_pop;
  logic       cfg_write;

  // Register file: no wait states, written in the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.function_set    <= RST_FUNCTION_SET;
      cfg_r.display_control <= RST_DISPLAY_CONTROL;
      cfg_r.clear           <= RST_CLEAR;
      cfg_r.entry_mode      <= RST_ENTRY_MODE;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_FUNCTION_SET:    cfg_r.function_set    <= pwdata[7:0];
        REG_DISPLAY_CONTROL: cfg_r.display_control <= pwdata[7:0];
        REG_CLEAR:           cfg_r.clear           <= pwdata[7:0];
        REG_ENTRY_MODE:      cfg_r.entry_mode      <= pwdata[7:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FUNCTION_SET:    prdata = {24'h0, cfg_r.function_set};
      REG_DISPLAY_CONTROL: prdata = {24'h0, cfg_r.display_control};
      REG_CLEAR:           prdata = {24'h0, cfg_r.clear};
      REG_ENTRY_MODE:      prdata = {24'h0, cfg_r.entry_mode};
      default:             prdata = 32'h0;
    endcase
  end

  // Hold off requests while the queue is full
  assign in_stall = q_full;

  lcdns_front u_front (
    .req  (in_data),
    .desc (front_desc)
  );

  lcdns_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_data  (front_desc),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_data  (head_desc)
  );

  // Drop the queue head once its final strobe enters the output stage
  lcdns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_desc),
    .pop        (head_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

[tb/tb_lcd_nibble_command_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_nibble_command_sequencer: request-to-strobe checker for the LCD sequencer
// Drives init, byte write, cursor goto and glyph load requests with random
// gaps and back-pressure, predicts every strobe in the bench and compares each
// strobe transfer field by field in order. The init command registers are
// written over the APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb_lcd_nibble_command_sequencer;
  import lcdns_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bench copy of the four init command bytes, indexed by register index
  logic [7:0]  init_word [4];

  // Strobes still owed by the block, oldest first
  out_item_t   pending_strobes [$];

  int          mismatch_count = 0;

  // Idle and stall rates in percent, set per phase by the tests
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  // Long receiver hold-off, counted down by the receiver process
  int          hold_off_cycles = 0;

  lcd_nibble_command_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Strobe predictor
  // --------------------------------------------------------------------------

  // Queue one strobe; the last flag is patched once the request is expanded
  function automatic void push_strobe(input logic rs, input logic [3:0] nib,
                                      input logic [3:0] before_ms,
                                      input logic [2:0] after_ms);
    out_item_t s;
    s.reg_select_out = rs;
    s.nibble         = nib;
    s.wait_before_ms = before_ms;
    s.wait_after_ms  = after_ms;
    s.last           = 1'b0;
    pending_strobes.push_back(s);
  endfunction

  // A byte goes out high nibble first; only the low nibble carries a tail wait
  function automatic void push_byte(input logic rs, input logic [7:0] b,
                                    input logic [2:0] after_ms);
    push_strobe(rs, b[7:4], 4'd0, 3'd0);
    push_strobe(rs, b[3:0], 4'd0, after_ms);
  endfunction

  // Expand one accepted request into the strobes it must produce
  function automatic void expand_request(input in_item_t req);
    logic [7:0] ddram_addr;
    out_item_t  tail;
    case (req.func)
      FUNC_INIT: begin
        // Power-up wait, three wake-up nibbles, switch to 4-bit mode
        push_strobe(1'b0, WAKE_NIBBLE, POWERUP_WAIT_MS, INIT_WAIT_MS);
        push_strobe(1'b0, WAKE_NIBBLE, 4'd0, INIT_WAIT_MS);
        push_strobe(1'b0, WAKE_NIBBLE, 4'd0, INIT_WAIT_MS);
        push_strobe(1'b0, FOURBIT_NIBBLE, 4'd0, INIT_WAIT_MS);
        push_byte(1'b0, init_word[REG_FUNCTION_SET], INIT_WAIT_MS);
        push_byte(1'b0, init_word[REG_DISPLAY_CONTROL], INIT_WAIT_MS);
        push_byte(1'b0, init_word[REG_CLEAR], INIT_WAIT_MS);
        push_byte(1'b0, init_word[REG_ENTRY_MODE], TAIL_WAIT_MS);
      end
      FUNC_WRITE: begin
        push_byte(req.register_select, req.data_byte, 3'd0);
      end
      FUNC_GOTO: begin
        // Column counts from 1; the 8-bit sum wraps on its own
        ddram_addr = ((req.row != ROW_FIRST) ? ROW_TWO_BASE : 8'h00) + req.column - 8'd1;
        push_byte(1'b0, CMD_SET_DDRAM | ddram_addr, 3'd0);
      end
      default: begin
        push_byte(1'b0, CMD_SET_CGRAM | ({2'b00, req.char_slot, 3'b000} & CGRAM_SLOT_MSK), 3'd0);
        for (int k = 0; k < 8; k++) push_byte(1'b1, req.glyph_rows[8*k +: 8], 3'd0);
      end
    endcase
    tail = pending_strobes.pop_back();
    tail.last = 1'b1;
    pending_strobes.push_back(tail);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on request transfers, check on strobe transfers. Both sit
  // in one process so that a prediction is always queued before a strobe at
  // the same edge is checked.
  // --------------------------------------------------------------------------
  task automatic report_field(input string field, input logic [3:0] want_v,
                              input logic [3:0] got_v);
    mismatch_count++;
    $display("%0t ns: strobe %s mismatch: expected %h, got %h", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin : strobe_monitor
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expand_request(in_data);
      if (out_valid && !out_stall) begin
        if (pending_strobes.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected strobe: expected none, got %h", $time, out_data);
        end else begin
          want = pending_strobes.pop_front();
          if (out_data.reg_select_out !== want.reg_select_out)
            report_field("register select", 4'(want.reg_select_out),
                         4'(out_data.reg_select_out));
          if (out_data.nibble !== want.nibble)
            report_field("nibble", want.nibble, out_data.nibble);
          if (out_data.wait_before_ms !== want.wait_before_ms)
            report_field("wait before", want.wait_before_ms, out_data.wait_before_ms);
          if (out_data.wait_after_ms !== want.wait_after_ms)
            report_field("wait after", 4'(want.wait_after_ms), 4'(out_data.wait_after_ms));
          if (out_data.last !== want.last)
            report_field("last", 4'(want.last), 4'(out_data.last));
        end
      end
    end
  end

  // Receiver: hold off for a counted stretch when asked, else stall at random
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall = 1'b1;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task starts and ends at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one request after a random gap, hold it until the transfer, then
  // drop valid again
  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data  = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Pause the sender until every owed strobe has come out
  task automatic wait_for_strobes();
    while (pending_strobes.size() != 0) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Read a register back and compare it with the bench copy
  task automatic check_register(input logic [1:0] idx);
    logic [31:0] rdata;
    apb_access(1'b0, idx, 32'h0, rdata);
    if (rdata[7:0] !== init_word[idx]) begin
      mismatch_count++;
      $display("%0t ns: register %0d readback mismatch: expected %h, got %h",
               $time, idx, init_word[idx], rdata[7:0]);
    end
  endtask

  // Write a register with junk above bit 7, which the block must drop
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] rdata;
    apb_access(1'b1, idx, {24'($urandom_range(32'hFF_FFFF)), val}, rdata);
    init_word[idx] = val;
    check_register(idx);
  endtask

  task automatic set_init_words(input logic [7:0] fs, input logic [7:0] dc,
                                input logic [7:0] cl, input logic [7:0] em);
    cfg_write(REG_FUNCTION_SET, fs);
    cfg_write(REG_DISPLAY_CONTROL, dc);
    cfg_write(REG_CLEAR, cl);
    cfg_write(REG_ENTRY_MODE, em);
  endtask

  function automatic in_item_t make_request(input logic [1:0] func, input logic rs,
                                            input logic [7:0] data_byte,
                                            input logic [7:0] column,
                                            input logic [1:0] row,
                                            input logic [2:0] slot,
                                            input logic [63:0] glyph_rows);
    in_item_t r;
    r.func            = func;
    r.register_select = rs;
    r.data_byte       = data_byte;
    r.column          = column;
    r.row             = row;
    r.char_slot       = slot;
    r.glyph_rows      = glyph_rows;
    return r;
  endfunction

  // Fully random request; fields a request does not name are random too
  function automatic in_item_t random_request();
    return make_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        2'($urandom_range(3)), 3'($urandom_range(7)),
                        {$urandom, $urandom});
  endfunction

  // Four random init command bytes
  task automatic set_random_init_words();
    set_init_words(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values, every request kind, field extremes and address wrap-around
  task automatic test_directed();
    check_register(REG_FUNCTION_SET);
    check_register(REG_DISPLAY_CONTROL);
    check_register(REG_CLEAR);
    check_register(REG_ENTRY_MODE);
    // init with the reset command bytes
    send_request(make_request(FUNC_INIT, 1'b0, 8'h00, 8'h00, 2'd0, 3'd0, 64'h0));
    // byte writes to both registers, with unused fields all zeros and all ones
    send_request(make_request(FUNC_WRITE, 1'b0, 8'h00, 8'h00, 2'd0, 3'd0, 64'h0));
    send_request(make_request(FUNC_WRITE, 1'b1, 8'hFF, 8'hFF, 2'd3, 3'd7, '1));
    send_request(make_request(FUNC_WRITE, 1'b1, 8'hA5, 8'h00, 2'd0, 3'd0, 64'h0));
    send_request(make_request(FUNC_WRITE, 1'b0, 8'h5A, 8'hFF, 2'd3, 3'd7, '1));
    // goto: home, column 0 wraps below the line base, columns past the top
    send_request(make_request(FUNC_GOTO, 1'b1, 8'hFF, 8'd1, ROW_FIRST, 3'd7, '1));
    send_request(make_request(FUNC_GOTO, 1'b0, 8'h00, 8'd0, ROW_FIRST, 3'd0, 64'h0));
    send_request(make_request(FUNC_GOTO, 1'b0, 8'h00, 8'd255, 2'd0, 3'd0, 64'h0));
    send_request(make_request(FUNC_GOTO, 1'b0, 8'h00, 8'h40, 2'd2, 3'd0, 64'h0));
    send_request(make_request(FUNC_GOTO, 1'b0, 8'h00, 8'hC1, 2'd3, 3'd0, 64'h0));
    send_request(make_request(FUNC_GOTO, 1'b0, 8'h00, 8'h80, ROW_FIRST, 3'd0, 64'h0));
    send_request(make_request(FUNC_GOTO, 1'b0, 8'h00, 8'd0, 2'd0, 3'd0, 64'h0));
    // glyph loads: lowest and highest slot, empty and full patterns, two mixed ones
    send_request(make_request(FUNC_GLYPH, 1'b1, 8'hFF, 8'hFF, 2'd3, 3'd0, 64'h0));
    send_request(make_request(FUNC_GLYPH, 1'b0, 8'h00, 8'h00, 2'd0, 3'd7, '1));
    send_request(make_request(FUNC_GLYPH, 1'b0, 8'h00, 8'h00, 2'd0, 3'd5,
                              64'h0123_4567_89AB_CDEF));
    send_request(make_request(FUNC_GLYPH, 1'b1, 8'h00, 8'h00, 2'd1, 3'd2,
                              64'h8000_0000_0000_0001));
    // init again, now with junk in every unused field
    send_request(make_request(FUNC_INIT, 1'b1, 8'hFF, 8'hFF, 2'd3, 3'd7, '1));
    wait_for_strobes();
  endtask

  // Init command bytes at their extremes and at a random mix
  task automatic test_init_words();
    set_init_words(8'h00, 8'h00, 8'h00, 8'h00);
    send_request(make_request(FUNC_INIT, 1'b0, 8'h00, 8'h00, 2'd0, 3'd0, 64'h0));
    send_request(random_request());
    wait_for_strobes();
    set_init_words(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(make_request(FUNC_INIT, 1'b0, 8'h00, 8'h00, 2'd0, 3'd0, 64'h0));
    send_request(random_request());
    wait_for_strobes();
    set_random_init_words();
    send_request(make_request(FUNC_INIT, 1'b0, 8'h00, 8'h00, 2'd0, 3'd0, 64'h0));
    send_request(random_request());
    wait_for_strobes();
  endtask

  // Hold the receiver off while the sender keeps offering, so the request
  // queue fills and in_stall rises; then pause the sender between bursts
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_cycles = 400;
    for (int k = 0; k < 10; k++) send_request(random_request());
    wait_for_strobes();
    stall_pct = 30;
    for (int k = 0; k < 5; k++) begin
      send_request(random_request());
      send_request(random_request());
      wait_for_strobes();
    end
  endtask

  // Random traffic under one idling pattern, with fresh init bytes each phase
  task automatic test_random_traffic(input int idle_pct, input int rx_stall_pct,
                                     input int n_items);
    wait_for_strobes();
    set_random_init_words();
    send_idle_pct = idle_pct;
    stall_pct     = rx_stall_pct;
    for (int k = 0; k < n_items; k++) send_request(random_request());
    wait_for_strobes();
  endtask

  initial begin
    init_word[REG_FUNCTION_SET]    = RST_FUNCTION_SET;
    init_word[REG_DISPLAY_CONTROL] = RST_DISPLAY_CONTROL;
    init_word[REG_CLEAR]           = RST_CLEAR;
    init_word[REG_ENTRY_MODE]      = RST_ENTRY_MODE;

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_init_words();
    test_backpressure();
    test_random_traffic(0, 0, 96);
    test_random_traffic(79, 0, 96);
    test_random_traffic(0, 79, 96);
    test_random_traffic(11, 11, 96);

    // Let any stray strobe show itself before the verdict
    wait_for_strobes();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
